### sv/pics_pkg.sv
// Shared definitions for the prime implicant cover selector.
// Holds codes, default sizes and the control structs that pass between modules.
// No dependencies.
`default_nettype none

package pics_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_IMPLICANTS_DEF      = 64;
    localparam int MAX_MINTERMS_DEF        = 64;
    localparam int SCORE_FRACTION_BITS_DEF = 16;

    // Fixed field widths of the channels and the configuration port.
    localparam int ROW_INDEX_W  = 6;
    localparam int COVER_ROW_W  = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int STRATEGY_W   = 2;
    localparam int COUNT_W      = 7;
    localparam int RESULT_CNT_W = 7;
    localparam int MAX_RESULTS  = 64;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STRATEGY        = 2'd0,
        CFG_IMPLICANT_COUNT = 2'd1,
        CFG_MINTERM_COUNT   = 2'd2
    } cfg_index_t;

    localparam logic [STRATEGY_W-1:0] STRAT_LARGEST   = 2'd0;
    localparam logic [STRATEGY_W-1:0] STRAT_COVER_SUM = 2'd1;
    localparam logic [STRATEGY_W-1:0] STRAT_SCORE     = 2'd2;

    // Port enables of the chart memories.
    typedef struct packed {
        logic cov_we;
        logic cov_re;
        logic wk_we;
        logic wk_re;
    } mem_ctl_t;

    // Commands to the weighing unit.
    typedef struct packed {
        logic clear_counts;
        logic add_counts;
        logic scan_start;
        logic best_init;
        logic cmp;
    } weigh_ctl_t;

endpackage

`default_nettype wire

### sv/pics_if.sv
// Channel interfaces of the prime implicant cover selector.
// Depends on pics_pkg for the field widths.
`default_nettype none

interface pics_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [pics_pkg::ROW_INDEX_W-1:0]     row_index;
    logic [pics_pkg::COVER_ROW_W-1:0]     cover_row;

    modport source (output valid, output opcode, output row_index, output cover_row,
                    input ready);
    modport sink   (input valid, input opcode, input row_index, input cover_row,
                    output ready);
endinterface

interface pics_pick_if;
    logic                             valid;
    logic                             ready;
    logic [pics_pkg::ROW_INDEX_W-1:0] chosen_index;
    logic                             none_chosen;
    logic                             last_pick;

    modport source (output valid, output chosen_index, output none_chosen, output last_pick,
                    input ready);
    modport sink   (input valid, input chosen_index, input none_chosen, input last_pick,
                    output ready);
endinterface

`default_nettype wire

### sv/pics_chart.sv
// Chart storage: the loaded coverage rows and the working copy used by a run.
// Depends on pics_pkg for the memory control struct.
`default_nettype none

module pics_chart #(
    parameter int MAX_IMPLICANTS = pics_pkg::MAX_IMPLICANTS_DEF,
    parameter int MAX_MINTERMS   = pics_pkg::MAX_MINTERMS_DEF
) (
    input  wire                              clk,
    input  pics_pkg::mem_ctl_t               ctl,
    input  wire [$clog2(MAX_IMPLICANTS)-1:0] cov_waddr,
    input  wire [MAX_MINTERMS-1:0]           cov_wdata,
    input  wire [$clog2(MAX_IMPLICANTS)-1:0] cov_raddr,
    output logic [MAX_MINTERMS-1:0]          cov_rdata,
    input  wire [$clog2(MAX_IMPLICANTS)-1:0] wk_waddr,
    input  wire [MAX_MINTERMS-1:0]           wk_wdata,
    input  wire [$clog2(MAX_IMPLICANTS)-1:0] wk_raddr,
    output logic [MAX_MINTERMS-1:0]          wk_rdata
);

    logic [MAX_MINTERMS-1:0] cov_mem [MAX_IMPLICANTS];
    logic [MAX_MINTERMS-1:0] wk_mem  [MAX_IMPLICANTS];

    always_ff @(posedge clk)
    begin
        if (ctl.cov_we)
        begin
            cov_mem[cov_waddr] <= cov_wdata;
        end
        if (ctl.cov_re)
        begin
            cov_rdata <= cov_mem[cov_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wk_we)
        begin
            wk_mem[wk_waddr] <= wk_wdata;
        end
        if (ctl.wk_re)
        begin
            wk_rdata <= wk_mem[wk_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/pics_weigh.sv
// Weighing unit: per-minterm cover counts, a one-minterm-per-cycle row scan
// and the best-row tracker. Depends on pics_pkg.
`default_nettype none

module pics_weigh #(
    parameter int MAX_IMPLICANTS      = pics_pkg::MAX_IMPLICANTS_DEF,
    parameter int MAX_MINTERMS        = pics_pkg::MAX_MINTERMS_DEF,
    parameter int SCORE_FRACTION_BITS = pics_pkg::SCORE_FRACTION_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  pics_pkg::weigh_ctl_t                  ctl,
    input  wire [pics_pkg::STRATEGY_W-1:0]        strategy,
    input  wire [MAX_MINTERMS-1:0]                row,
    input  wire [$clog2(MAX_IMPLICANTS)-1:0]      row_pos,
    output logic                                  scan_busy,
    output logic [$clog2(MAX_MINTERMS+1)-1:0]     best_size,
    output logic [$clog2(MAX_IMPLICANTS)-1:0]     best_pos
);

    localparam int IW       = $clog2(MAX_IMPLICANTS);
    localparam int JW       = $clog2(MAX_MINTERMS);
    localparam int MW       = $clog2(MAX_MINTERMS + 1);
    localparam int CW       = pics_pkg::COUNT_W;
    localparam int F        = SCORE_FRACTION_BITS;
    localparam int SUM_W    = CW + MW;
    localparam int SCORE_W  = F + MW;
    localparam int RECIP_N  = 2 ** CW;
    localparam int RECIP_MX = (2 ** F) - 1;

    // Reciprocal table, 2^F/n rounded half up and saturated; zero maps to zero.
    logic [F-1:0] recip_tab [RECIP_N];

    for (genvar g = 0; g < RECIP_N; g++)
    begin : g_recip
        localparam int Div = (g == 0) ? 1 : g;
        localparam int Raw = ((2 ** F) + Div / 2) / Div;
        localparam int Val = (g == 0) ? 0 : ((Raw > RECIP_MX) ? RECIP_MX : Raw);
        assign recip_tab[g] = F'(Val);
    end

    logic [CW-1:0]           cnt_reg [MAX_MINTERMS];
    logic [MAX_MINTERMS-1:0] row_sh_reg;
    logic [JW-1:0]           step_reg;
    logic                    busy_reg;
    logic [MW-1:0]           size_acc_reg;
    logic [SUM_W-1:0]        sum_acc_reg;
    logic [SCORE_W-1:0]      score_acc_reg;
    logic [MW-1:0]           best_size_reg;
    logic [SUM_W-1:0]        best_sum_reg;
    logic [SCORE_W-1:0]      best_score_reg;
    logic [IW-1:0]           best_pos_reg;

    logic                    head_bit;
    logic [CW-1:0]           head_cnt;
    logic                    take_it;

    assign head_bit = row_sh_reg[0];
    assign head_cnt = cnt_reg[0];

    // Cover counts rotate during a scan so the head always holds the current minterm;
    // a full scan brings them back to their place.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < MAX_MINTERMS; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else if (ctl.clear_counts)
        begin
            for (int t = 0; t < MAX_MINTERMS; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else if (ctl.add_counts)
        begin
            for (int t = 0; t < MAX_MINTERMS; t++)
            begin
                cnt_reg[t] <= cnt_reg[t] + CW'(row[t]);
            end
        end
        else if (busy_reg)
        begin
            for (int t = 0; t < MAX_MINTERMS - 1; t++)
            begin
                cnt_reg[t] <= cnt_reg[t+1];
            end
            cnt_reg[MAX_MINTERMS-1] <= cnt_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (ctl.scan_start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + JW'(1);
            if (step_reg == JW'(MAX_MINTERMS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_start)
        begin
            row_sh_reg    <= row;
            size_acc_reg  <= '0;
            sum_acc_reg   <= '0;
            score_acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            row_sh_reg    <= {row_sh_reg[0], row_sh_reg[MAX_MINTERMS-1:1]};
            size_acc_reg  <= size_acc_reg + MW'(head_bit);
            sum_acc_reg   <= sum_acc_reg + (head_bit ? SUM_W'(head_cnt) : '0);
            score_acc_reg <= score_acc_reg + (head_bit ? SCORE_W'(recip_tab[head_cnt]) : '0);
        end
    end

    always_comb
    begin
        unique case (strategy)
            pics_pkg::STRAT_SCORE:
                take_it = (score_acc_reg > best_score_reg) ||
                          ((score_acc_reg == best_score_reg) && (size_acc_reg < best_size_reg));
            pics_pkg::STRAT_COVER_SUM:
                take_it = (size_acc_reg > best_size_reg) ||
                          ((size_acc_reg == best_size_reg) && (sum_acc_reg < best_sum_reg));
            default:
                take_it = size_acc_reg > best_size_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_size_reg  <= '0;
            best_sum_reg   <= '0;
            best_score_reg <= '0;
            best_pos_reg   <= '0;
        end
        else if (ctl.best_init)
        begin
            best_size_reg  <= '0;
            best_sum_reg   <= '0;
            best_score_reg <= '0;
            best_pos_reg   <= '0;
        end
        else if (ctl.cmp && take_it)
        begin
            best_size_reg  <= size_acc_reg;
            best_sum_reg   <= sum_acc_reg;
            best_score_reg <= score_acc_reg;
            best_pos_reg   <= row_pos;
        end
    end

    assign scan_busy = busy_reg;
    assign best_size = best_size_reg;
    assign best_pos  = best_pos_reg;

endmodule

`default_nettype wire

### sv/prime_implicant_cover_select.sv
// Prime implicant cover selector, top level with the run sequencer and output register.
// Depends on pics_pkg, pics_if, pics_chart and pics_weigh.
`default_nettype none

// A load transaction (opcode 0) writes one coverage row, so rows may stream in back
// to back. A start transaction (opcode 1) runs the whole cover selection and the
// block drops ready until the last pick has entered the output register. The run
// copies the n rows in use into a working chart, then walks the minterms for
// essential implicants, and each pick clears its minterms from every working row.
// Each greedy pass weighs every row through one shared accumulator that takes one
// minterm per cycle, and that scan sets the run length. Picks leave one transaction
// at a time and the run waits when the output register is still full. A run with no
// pick yields a single transaction with none_chosen set. Configuration registers are
// to be written only while the block is idle; the block itself does not enforce this.

module prime_implicant_cover_select #(
    parameter int MAX_IMPLICANTS      = pics_pkg::MAX_IMPLICANTS_DEF,
    parameter int MAX_MINTERMS        = pics_pkg::MAX_MINTERMS_DEF,
    parameter int SCORE_FRACTION_BITS = pics_pkg::SCORE_FRACTION_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    pics_item_if.sink                            item,
    pics_pick_if.source                          pick,
    input  wire                                  wr_en,
    input  wire [pics_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  wire [pics_pkg::CFG_DATA_W-1:0]       wr_data
);

    localparam int IW = $clog2(MAX_IMPLICANTS);
    localparam int NW = $clog2(MAX_IMPLICANTS + 1);
    localparam int JW = $clog2(MAX_MINTERMS);
    localparam int MW = $clog2(MAX_MINTERMS + 1);
    localparam int KW = pics_pkg::RESULT_CNT_W;
    localparam int OW = pics_pkg::ROW_INDEX_W;

    typedef enum logic [16:0] {
        S_IDLE       = 17'h00001,
        S_COPY_RD    = 17'h00002,
        S_COPY_WR    = 17'h00004,
        S_ESS_COL    = 17'h00008,
        S_ESS_RD     = 17'h00010,
        S_ESS_CHK    = 17'h00020,
        S_TAKE_FETCH = 17'h00040,
        S_TAKE_LATCH = 17'h00080,
        S_EMIT       = 17'h00100,
        S_TAKE_RD    = 17'h00200,
        S_TAKE_WR    = 17'h00400,
        S_GR_START   = 17'h00800,
        S_GR_RD      = 17'h01000,
        S_GR_LOAD    = 17'h02000,
        S_GR_SCAN    = 17'h04000,
        S_GR_DONE    = 17'h08000,
        S_FINISH     = 17'h10000
    } state_t;

    // Configuration registers.
    logic [pics_pkg::STRATEGY_W-1:0] strategy_reg;
    logic [pics_pkg::CFG_DATA_W-1:0] impl_cnt_reg;
    logic [pics_pkg::CFG_DATA_W-1:0] mint_cnt_reg;

    // Sequencer state.
    state_t                  state_reg, state_next;
    logic [NW-1:0]           i_reg, i_next;
    logic [MW-1:0]           j_reg, j_next;
    logic [1:0]              ess_cnt_reg, ess_cnt_next;
    logic [IW-1:0]           who_reg, who_next;
    logic [IW-1:0]           take_idx_reg, take_idx_next;
    logic [MAX_MINTERMS-1:0] cols_reg, cols_next;
    logic [MAX_MINTERMS-1:0] uncov_reg, uncov_next;
    logic                    greedy_reg, greedy_next;
    logic [KW-1:0]           k_reg, k_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [IW-1:0]           pend_idx_reg, pend_idx_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [OW-1:0]           out_index_reg, out_index_next;
    logic                    out_none_reg, out_none_next;
    logic                    out_last_reg, out_last_next;

    logic [NW-1:0]           n_val;
    logic [MW-1:0]           m_val;
    logic [MAX_MINTERMS-1:0] colmask;
    logic                    item_fire;
    logic                    out_free;
    logic                    load_ok;
    logic [JW-1:0]           j_idx;
    logic                    below_limit;

    pics_pkg::mem_ctl_t      mem_ctl;
    pics_pkg::weigh_ctl_t    wctl;
    logic [MAX_MINTERMS-1:0] cov_rdata;
    logic [MAX_MINTERMS-1:0] wk_rdata;
    logic [MAX_MINTERMS-1:0] wk_wdata;
    logic [IW-1:0]           wk_raddr;
    logic [MAX_MINTERMS-1:0] weigh_row;
    logic                    scan_busy;
    logic [MW-1:0]           best_size;
    logic [IW-1:0]           best_pos;

    // Counts clamp to the sizes the storage was built for.
    assign n_val = (int'(impl_cnt_reg) < MAX_IMPLICANTS) ? NW'(impl_cnt_reg) : NW'(MAX_IMPLICANTS);
    assign m_val = (int'(mint_cnt_reg) < MAX_MINTERMS) ? MW'(mint_cnt_reg) : MW'(MAX_MINTERMS);

    always_comb
    begin
        for (int t = 0; t < MAX_MINTERMS; t++)
        begin
            colmask[t] = t < int'(m_val);
        end
    end

    assign item.ready  = state_reg == S_IDLE;
    assign item_fire   = item.valid && item.ready;
    assign out_free    = !out_valid_reg || pick.ready;
    assign load_ok     = int'(item.row_index) < MAX_IMPLICANTS;
    assign j_idx       = j_reg[JW-1:0];
    assign below_limit = int'(k_reg) < pics_pkg::MAX_RESULTS;

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= '0;
            impl_cnt_reg <= '0;
            mint_cnt_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (pics_pkg::cfg_index_t'(wr_index))
                pics_pkg::CFG_STRATEGY:        strategy_reg <= wr_data[pics_pkg::STRATEGY_W-1:0];
                pics_pkg::CFG_IMPLICANT_COUNT: impl_cnt_reg <= wr_data;
                pics_pkg::CFG_MINTERM_COUNT:   mint_cnt_reg <= wr_data;
                default:                       ;
            endcase
        end
    end

    // Memory addressing. The working chart is written at the sweep index and read at the
    // sweep index, except when the row of a pick is fetched.
    assign wk_raddr  = (state_reg == S_TAKE_FETCH) ? take_idx_reg : i_reg[IW-1:0];
    assign wk_wdata  = (state_reg == S_COPY_WR) ? (cov_rdata & colmask) : (wk_rdata & ~cols_reg);
    assign weigh_row = (state_reg == S_COPY_WR) ? (cov_rdata & colmask) : wk_rdata;

    always_comb
    begin
        mem_ctl        = '0;
        mem_ctl.cov_we = item_fire && (item.opcode == pics_pkg::OP_LOAD) && load_ok;
        mem_ctl.cov_re = state_reg == S_COPY_RD && i_reg != n_val;
        mem_ctl.wk_we  = state_reg == S_COPY_WR || state_reg == S_TAKE_WR;
        mem_ctl.wk_re  = ((state_reg == S_ESS_RD || state_reg == S_GR_RD
                          || state_reg == S_TAKE_RD) && i_reg != n_val)
                         || state_reg == S_TAKE_FETCH;
    end

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        ess_cnt_next    = ess_cnt_reg;
        who_next        = who_reg;
        take_idx_next   = take_idx_reg;
        cols_next       = cols_reg;
        uncov_next      = uncov_reg;
        greedy_next     = greedy_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !pick.ready;
        out_index_next  = out_index_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;
        wctl            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && item.opcode == pics_pkg::OP_START)
                begin
                    i_next            = '0;
                    k_next            = '0;
                    greedy_next       = 1'b0;
                    pend_valid_next   = 1'b0;
                    uncov_next        = colmask;
                    wctl.clear_counts = 1'b1;
                    state_next        = S_COPY_RD;
                end
            end

            // Copy the rows in use into the working chart and count covers per minterm.
            S_COPY_RD:
            begin
                if (i_reg == n_val)
                begin
                    j_next     = '0;
                    state_next = S_ESS_COL;
                end
                else
                begin
                    state_next = S_COPY_WR;
                end
            end

            S_COPY_WR:
            begin
                wctl.add_counts = 1'b1;
                i_next          = i_reg + NW'(1);
                state_next      = S_COPY_RD;
            end

            // Essential implicants: each uncovered minterm, in order, is checked for
            // exactly one covering row.
            S_ESS_COL:
            begin
                if (j_reg == m_val)
                begin
                    state_next = S_GR_START;
                end
                else if (!uncov_reg[j_idx])
                begin
                    j_next = j_reg + MW'(1);
                end
                else
                begin
                    i_next       = '0;
                    ess_cnt_next = '0;
                    state_next   = S_ESS_RD;
                end
            end

            S_ESS_RD:
            begin
                if (i_reg == n_val)
                begin
                    if (ess_cnt_reg == 2'd1)
                    begin
                        take_idx_next = who_reg;
                        state_next    = S_TAKE_FETCH;
                    end
                    else
                    begin
                        j_next     = j_reg + MW'(1);
                        state_next = S_ESS_COL;
                    end
                end
                else
                begin
                    state_next = S_ESS_CHK;
                end
            end

            S_ESS_CHK:
            begin
                if (wk_rdata[j_idx])
                begin
                    who_next = i_reg[IW-1:0];
                    if (ess_cnt_reg != 2'd2)
                    begin
                        ess_cnt_next = ess_cnt_reg + 2'd1;
                    end
                end
                i_next     = i_reg + NW'(1);
                state_next = S_ESS_RD;
            end

            // A pick: fetch its row, drop its minterms, report it, then clear every row.
            S_TAKE_FETCH:
            begin
                state_next = S_TAKE_LATCH;
            end

            S_TAKE_LATCH:
            begin
                cols_next  = wk_rdata;
                uncov_next = uncov_reg & ~wk_rdata;
                state_next = S_EMIT;
            end

            // The newest pick waits in a holding slot so that the final one can carry
            // last_pick; the previous one moves to the output register.
            S_EMIT:
            begin
                if (!below_limit)
                begin
                    i_next     = '0;
                    state_next = S_TAKE_RD;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = OW'(pend_idx_reg);
                        out_none_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = take_idx_reg;
                    k_next          = k_reg + KW'(1);
                    i_next          = '0;
                    state_next      = S_TAKE_RD;
                end
            end

            S_TAKE_RD:
            begin
                if (i_reg == n_val)
                begin
                    if (greedy_reg)
                    begin
                        state_next = S_GR_START;
                    end
                    else
                    begin
                        j_next     = j_reg + MW'(1);
                        state_next = S_ESS_COL;
                    end
                end
                else
                begin
                    state_next = S_TAKE_WR;
                end
            end

            S_TAKE_WR:
            begin
                i_next     = i_reg + NW'(1);
                state_next = S_TAKE_RD;
            end

            // Greedy pass: weigh every row and keep the best by the selected rule.
            S_GR_START:
            begin
                greedy_next    = 1'b1;
                wctl.best_init = 1'b1;
                i_next         = '0;
                state_next     = S_GR_RD;
            end

            S_GR_RD:
            begin
                state_next = (i_reg == n_val) ? S_GR_DONE : S_GR_LOAD;
            end

            S_GR_LOAD:
            begin
                wctl.scan_start = 1'b1;
                state_next      = S_GR_SCAN;
            end

            S_GR_SCAN:
            begin
                if (!scan_busy)
                begin
                    wctl.cmp   = 1'b1;
                    i_next     = i_reg + NW'(1);
                    state_next = S_GR_RD;
                end
            end

            S_GR_DONE:
            begin
                if (best_size == '0 || !below_limit)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    take_idx_next = best_pos;
                    state_next    = S_TAKE_FETCH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = pend_valid_reg ? OW'(pend_idx_reg) : '0;
                    out_none_next   = !pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            ess_cnt_reg    <= '0;
            greedy_reg     <= 1'b0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            uncov_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            ess_cnt_reg    <= ess_cnt_next;
            greedy_reg     <= greedy_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            uncov_reg      <= uncov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        who_reg       <= who_next;
        take_idx_reg  <= take_idx_next;
        cols_reg      <= cols_next;
        pend_idx_reg  <= pend_idx_next;
        out_index_reg <= out_index_next;
        out_none_reg  <= out_none_next;
        out_last_reg  <= out_last_next;
    end

    assign pick.valid        = out_valid_reg;
    assign pick.chosen_index = out_index_reg;
    assign pick.none_chosen  = out_none_reg;
    assign pick.last_pick    = out_last_reg;

    pics_chart #(
        .MAX_IMPLICANTS (MAX_IMPLICANTS),
        .MAX_MINTERMS   (MAX_MINTERMS)
    ) u_chart (
        .clk       (clk),
        .ctl       (mem_ctl),
        .cov_waddr (IW'(item.row_index)),
        .cov_wdata (item.cover_row[MAX_MINTERMS-1:0]),
        .cov_raddr (i_reg[IW-1:0]),
        .cov_rdata (cov_rdata),
        .wk_waddr  (i_reg[IW-1:0]),
        .wk_wdata  (wk_wdata),
        .wk_raddr  (wk_raddr),
        .wk_rdata  (wk_rdata)
    );

    pics_weigh #(
        .MAX_IMPLICANTS      (MAX_IMPLICANTS),
        .MAX_MINTERMS        (MAX_MINTERMS),
        .SCORE_FRACTION_BITS (SCORE_FRACTION_BITS)
    ) u_weigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (wctl),
        .strategy  (strategy_reg),
        .row       (weigh_row),
        .row_pos   (i_reg[IW-1:0]),
        .scan_busy (scan_busy),
        .best_size (best_size),
        .best_pos  (best_pos)
    );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the prime implicant cover selector.
// Streams chart rows and start transactions into the block, predicts the picks of every
// start and checks each pick transaction. Depends on pics_pkg, pics_if and the RTL top.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index past the end of the register list; the block must ignore it.
    localparam logic [pics_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ROWS = pics_pkg::MAX_IMPLICANTS_DEF;
    localparam int COLS = pics_pkg::MAX_MINTERMS_DEF;
    localparam int FRAC = pics_pkg::SCORE_FRACTION_BITS_DEF;
    // The longest quiet stretch is one greedy pass over a full chart plus a long
    // receiver hold-off, so the watchdog allows many times that.
    localparam int IDLE_LIMIT = 200000;
    // Cycles to let a row load settle before a register write.
    localparam int SETTLE = 20;

    typedef struct {
        logic [pics_pkg::ROW_INDEX_W-1:0] chosen_index;
        logic                             none_chosen;
        logic                             last_pick;
    } pick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [pics_pkg::CFG_INDEX_W-1:0] wr_index = '0;
    logic [pics_pkg::CFG_DATA_W-1:0]  wr_data = '0;

    pics_item_if item ();
    pics_pick_if pick ();

    prime_implicant_cover_select DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item.sink),
        .pick     (pick.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the chart, the registers and the scratch state of a run.
    logic [pics_pkg::COVER_ROW_W-1:0] chart_rows [ROWS];
    logic [pics_pkg::COVER_ROW_W-1:0] work_chart [ROWS];
    int unsigned                      column_covers [COLS];
    logic [pics_pkg::STRATEGY_W-1:0]  sel_strategy = '0;
    logic [pics_pkg::COUNT_W-1:0]     row_limit = '0;
    logic [pics_pkg::COUNT_W-1:0]     col_limit = '0;

    pick_t pending_picks [$];  // picks predicted and not yet seen
    pick_t run_picks [$];      // picks of the start being predicted

    int errors = 0;
    int idle_cycles = 0;
    int random_items = 0;
    bit calm = 1'b0;      // when set, neither side inserts gaps
    int hold_off = 0;     // long receiver stall requested by a test

    initial begin
        item.valid     = 1'b0;
        item.opcode    = pics_pkg::OP_LOAD;
        item.row_index = '0;
        item.cover_row = '0;
        pick.ready     = 1'b0;
    end

    // Reciprocal of a cover count in Q0.FRAC, rounded half up and saturated below one.
    function automatic longint unsigned recip_q(int unsigned n);
        longint unsigned one;
        longint unsigned r;
        one = 64'd1 << FRAC;
        if (n == 0)
            return 0;
        r = (one + n / 2) / n;
        return (r > one - 1) ? one - 1 : r;
    endfunction

    // Sum over the set columns of a row of either the cover count or its reciprocal.
    function automatic longint unsigned row_weight(logic [pics_pkg::COVER_ROW_W-1:0] row,
                                                   int m, bit use_score);
        longint unsigned s;
        s = 0;
        for (int j = 0; j < m; j++)
            if (row[j])
                s += use_score ? recip_q(column_covers[j]) : column_covers[j];
        return s;
    endfunction

    // Record a pick and strike its minterms from every working row.
    function automatic void take_row(int i, int n);
        logic [pics_pkg::COVER_ROW_W-1:0] cols;
        pick_t p;
        cols = work_chart[i];
        if (run_picks.size() < pics_pkg::MAX_RESULTS)
        begin
            p.chosen_index = i[pics_pkg::ROW_INDEX_W-1:0];
            p.none_chosen  = 1'b0;
            p.last_pick    = 1'b0;
            run_picks.insert(run_picks.size(), p);
        end
        for (int r = 0; r < n; r++)
            work_chart[r] &= ~cols;
    endfunction

    // Works out the full pick sequence of one start and queues it.
    function automatic void predict_cover();
        int n;
        int m;
        logic [pics_pkg::COVER_ROW_W-1:0] colmask;
        logic [pics_pkg::COVER_ROW_W-1:0] uncovered;
        int c;
        int who;
        int pos;
        int sz;
        int best_size;
        longint unsigned s;
        longint unsigned best_sum;
        pick_t p;
        n = (row_limit > ROWS) ? ROWS : row_limit;
        m = (col_limit > COLS) ? COLS : col_limit;
        colmask = (m >= 64) ? '1 : ((64'd1 << m) - 1);
        run_picks.delete();
        for (int i = 0; i < ROWS; i++)
            work_chart[i] = (i < n) ? (chart_rows[i] & colmask) : '0;
        for (int j = 0; j < COLS; j++)
        begin
            c = 0;
            if (j < m)
                for (int i = 0; i < n; i++)
                    c += work_chart[i][j];
            column_covers[j] = c;
        end
        uncovered = colmask;

        // Essential implicants: a still-uncovered minterm with a single cover.
        for (int j = 0; j < m; j++)
        begin
            c = 0;
            who = 0;
            for (int i = 0; i < n; i++)
                if (work_chart[i][j])
                begin
                    c++;
                    who = i;
                end
            if (uncovered[j] && c == 1)
            begin
                uncovered &= ~work_chart[who];
                take_row(who, n);
            end
        end

        // Greedy picks until no row covers anything left or the result limit is reached.
        forever
        begin
            pos = 0;
            best_size = 0;
            best_sum = 0;
            for (int i = 0; i < n; i++)
            begin
                sz = $countones(work_chart[i]);
                if (sel_strategy == pics_pkg::STRAT_SCORE)
                begin
                    s = row_weight(work_chart[i], m, 1'b1);
                    if (s >= best_sum && (s > best_sum || sz < best_size))
                    begin
                        best_sum = s;
                        best_size = sz;
                        pos = i;
                    end
                end
                else if (sel_strategy == pics_pkg::STRAT_COVER_SUM)
                begin
                    if (sz >= best_size)
                    begin
                        s = row_weight(work_chart[i], m, 1'b0);
                        if (sz > best_size || s < best_sum)
                        begin
                            best_size = sz;
                            best_sum = s;
                            pos = i;
                        end
                    end
                end
                else if (sz > best_size)
                begin
                    best_size = sz;
                    pos = i;
                end
            end
            if (best_size == 0 || run_picks.size() >= pics_pkg::MAX_RESULTS)
                break;
            take_row(pos, n);
        end

        if (run_picks.size() == 0)
        begin
            p.chosen_index = '0;
            p.none_chosen  = 1'b1;
            p.last_pick    = 1'b1;
            run_picks.insert(run_picks.size(), p);
        end
        else
            run_picks[run_picks.size() - 1].last_pick = 1'b1;
        foreach (run_picks[k])
            pending_picks.insert(pending_picks.size(), run_picks[k]);
    endfunction

    // Offers one transaction after a random gap and updates the shadow state once it
    // is accepted. Valid is only lowered when a gap follows, never in the accept step.
    task automatic send_item(pics_pkg::opcode_t op, logic [pics_pkg::ROW_INDEX_W-1:0] idx,
                             logic [pics_pkg::COVER_ROW_W-1:0] row);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid     <= 1'b1;
        item.opcode    <= op;
        item.row_index <= idx;
        item.cover_row <= row;
        do @(posedge clk); while (!item.ready);
        if (op == pics_pkg::OP_LOAD)
            chart_rows[idx] = row;
        else
            predict_cover();
    endtask

    task automatic load_row(int idx, logic [pics_pkg::COVER_ROW_W-1:0] row);
        send_item(pics_pkg::OP_LOAD, idx[pics_pkg::ROW_INDEX_W-1:0], row);
    endtask

    task automatic start_run();
        send_item(pics_pkg::OP_START, pics_pkg::ROW_INDEX_W'($urandom_range(0, 63)),
                  {$urandom, $urandom});
    endtask

    // Registers change only once every predicted pick has come out and any load
    // still inside the block has had time to land. The last offered transaction is
    // withdrawn first so that it is not taken a second time.
    task automatic wait_idle();
        item.valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [pics_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pics_pkg::CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            pics_pkg::CFG_STRATEGY:        sel_strategy = data[pics_pkg::STRATEGY_W-1:0];
            pics_pkg::CFG_IMPLICANT_COUNT: row_limit = data;
            pics_pkg::CFG_MINTERM_COUNT:   col_limit = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(logic [pics_pkg::STRATEGY_W-1:0] strat, int n, int m);
        wait_idle();
        write_reg(pics_pkg::CFG_STRATEGY, pics_pkg::CFG_DATA_W'(strat));
        write_reg(pics_pkg::CFG_IMPLICANT_COUNT, n[pics_pkg::CFG_DATA_W-1:0]);
        write_reg(pics_pkg::CFG_MINTERM_COUNT, m[pics_pkg::CFG_DATA_W-1:0]);
    endtask

    // Random coverage row whose density is set by how many words are ANDed together.
    function automatic logic [pics_pkg::COVER_ROW_W-1:0] random_row(int sparsity);
        logic [pics_pkg::COVER_ROW_W-1:0] r;
        r = {$urandom, $urandom};
        for (int k = 0; k < sparsity; k++)
            r &= {$urandom, $urandom};
        return r;
    endfunction

    // A start straight after reset and a start with zero rows configured have no rows in use and must report no pick.
    task automatic test_empty_chart();
        start_run();
        configure(pics_pkg::STRAT_LARGEST, 0, 8);
        start_run();
    endtask

    // A small hand-built chart with essential rows, overlapping rows and ties, run
    // under every strategy, the unused strategy code and an ignored register index.
    task automatic test_small_chart();
        configure(pics_pkg::STRAT_LARGEST, 6, 8);
        write_reg(CFG_UNUSED, 7'h7f);
        load_row(0, 64'h0000_0000_0000_0003);
        load_row(1, 64'h0000_0000_0000_0006);
        load_row(2, 64'h0000_0000_0000_000c);
        load_row(3, 64'h0000_0000_0000_0038);
        load_row(4, 64'h0000_0000_0000_0070);
        load_row(5, 64'hffff_ffff_ffff_ff80);
        load_row(63, '1);
        load_row(42, 64'h8000_0000_0000_0001);
        start_run();
        for (int s = 1; s < 4; s++)
        begin
            configure(s[pics_pkg::STRATEGY_W-1:0], 6, 8);
            start_run();
        end
        configure(pics_pkg::STRAT_SCORE, 6, 0);
        start_run();
    endtask

    // Fills the whole chart and runs at the largest sizes, with counts above the
    // maximum that must be clamped.
    task automatic test_full_chart();
        configure(pics_pkg::STRAT_LARGEST, 64, 64);
        for (int i = 0; i < ROWS; i++)
            load_row(i, random_row(2));
        start_run();
        configure(pics_pkg::STRAT_SCORE, 127, 100);
        start_run();
        configure(pics_pkg::STRAT_COVER_SUM, 64, 64);
        start_run();
    endtask

    // Streams rows and a start while the receiver stays stalled, so the output
    // register fills and the block has to hold off its input.
    task automatic test_output_backpressure();
        configure(pics_pkg::STRAT_LARGEST, 12, 16);
        for (int i = 0; i < 12; i++)
            load_row(i, random_row(1));
        hold_off = 400;
        start_run();
        for (int i = 0; i < 12; i++)
            load_row(i, random_row(1));
        start_run();
    endtask

    // Random phases: new registers, a freshly loaded chart, then one or two starts.
    // Most phases are small; a few use every column. Some extra loads land on random rows,
    // often outside the active set, as noise.
    task automatic test_random_runs();
        int n;
        int m;
        int sparsity;
        logic [pics_pkg::STRATEGY_W-1:0] strat;
        while (random_items < 16)
        begin
            strat = pics_pkg::STRATEGY_W'($urandom_range(0, 3));
            n = $urandom_range(1, 10);
            m = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 20);
            sparsity = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            configure(strat, n, m);
            for (int i = 0; i < n; i++)
            begin
                load_row(i, random_row(sparsity));
                random_items++;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                load_row($urandom_range(0, 63), random_row(0));
                random_items++;
            end
            start_run();
            random_items++;
            if ($urandom_range(0, 3) == 0)
            begin
                start_run();
                random_items++;
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: a random stall after each accepted pick, or a long hold-off on request.
    initial
    begin : pick_receiver
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        pick.ready <= 1'b1;
        forever
        begin
            do @(posedge clk); while (!(pick.valid && pick.ready) && hold_off == 0);
            if (hold_off > 0)
                stall = hold_off;
            else
                stall = calm ? 0 : $urandom_range(0, 8);
            hold_off = 0;
            if (stall > 0)
            begin
                pick.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                pick.ready <= 1'b1;
            end
        end
    end

    // Every accepted pick must match the oldest prediction field by field.
    always @(posedge clk)
    begin : pick_checker
        pick_t exp_pick;
        if (pick.valid && pick.ready)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("unexpected pick transaction, chosen_index %0d", pick.chosen_index);
                errors++;
            end
            else
            begin
                exp_pick = pending_picks.pop_front();
                if (pick.chosen_index !== exp_pick.chosen_index)
                begin
                    $error("chosen_index expected %0d actual %0d",
                           exp_pick.chosen_index, pick.chosen_index);
                    errors++;
                end
                if (pick.none_chosen !== exp_pick.none_chosen)
                begin
                    $error("none_chosen expected %0d actual %0d",
                           exp_pick.none_chosen, pick.none_chosen);
                    errors++;
                end
                if (pick.last_pick !== exp_pick.last_pick)
                begin
                    $error("last_pick expected %0d actual %0d",
                           exp_pick.last_pick, pick.last_pick);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (pick.valid && pick.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        foreach (chart_rows[i])
            chart_rows[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_chart();
        test_small_chart();
        test_full_chart();
        test_output_backpressure();
        test_random_runs();

        item.valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

`default_nettype wire

### filelist.f
sv/pics_pkg.sv
sv/pics_if.sv
sv/pics_chart.sv
sv/pics_weigh.sv
sv/prime_implicant_cover_select.sv
bench/tb.sv
